// ----- rtl/okvt_pkg.sv -----
// ============================================================================
// okvt_pkg
// Shared types and codes for the ordered key/value table.
// ============================================================================
package okvt_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_PUT    = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_NOP    = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOTFOUND = 2'd1;
    localparam status_t ST_FULL     = 2'd2;

    localparam int KEY_IN_W   = 32;
    localparam int VAL_IN_W   = 32;
    localparam int VAL_OUT_W  = 32;
    localparam int CNT_OUT_W  = 5;
    localparam int IN_DATA_W  = ((KEY_IN_W + VAL_IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_OUT_W + CNT_OUT_W + 7) / 8) * 8;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

endpackage

// ----- rtl/okvt_ram.sv -----
// ============================================================================
// okvt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ordered_key_value_table.sv -----
// ============================================================================
// ordered_key_value_table
// Insertion-ordered key/value table with linear search, put and remove.
// ============================================================================
// Requests arrive one word at a time; the table holds up to DEPTH entries in
// one RAM (key and value side by side) and walks it one entry per cycle
// through the single read port. A search stops at the entry that holds the
// key, or runs through all entries in use when the key is missing; the unused
// code goes straight to the result. A remove then copies each later entry
// down one place through the same read and write ports, so the search and the
// shift together visit each entry in use once. The next request is taken
// once the result has moved into the output register. A finished result
// waits in an output register, so the next request is taken while the
// previous result is still pending; a second finished result stalls the input
// until the first one leaves.
module ordered_key_value_table #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [okvt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // key, value_in
    input  logic [okvt_pkg::OP_W-1:0]        s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [okvt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // value_out, entry_count
    output logic [okvt_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = KEY_W + VAL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_MISS   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                       state_reg, state_next;
    okvt_pkg::op_t                    op_reg, op_next;
    logic [KEY_W-1:0]                 key_reg, key_next;
    logic [VAL_W-1:0]                 val_reg, val_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [CW-1:0]                    fill_reg, fill_next;
    logic [okvt_pkg::VAL_OUT_W-1:0]   res_val_reg, res_val_next;
    okvt_pkg::status_t                res_status_reg, res_status_next;

    logic                             out_valid_reg, out_valid_next;
    logic [okvt_pkg::VAL_OUT_W-1:0]   out_val_reg, out_val_next;
    okvt_pkg::status_t                out_status_reg, out_status_next;
    logic [okvt_pkg::CNT_OUT_W-1:0]   out_count_reg, out_count_next;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [MW-1:0]                    ram_wdata;
    logic [AW-1:0]                    ram_raddr;
    logic [MW-1:0]                    ram_rdata;

    logic                             accept;
    logic                             load_out;
    logic                             hit;
    logic [CW-1:0]                    idx_inc;
    logic                             more;

    okvt_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_out      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    assign hit     = (ram_rdata[KEY_W-1:0] == key_reg);
    assign idx_inc = CW'(idx_reg) + CW'(1);
    assign more    = (idx_inc < fill_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {val_reg, key_reg};
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = s_axis_tuser;
                    key_next        = KEY_W'(s_axis_tdata[okvt_pkg::KEY_IN_W-1:0]);
                    val_next        = VAL_W'(s_axis_tdata[okvt_pkg::IN_DATA_W-1:
                                                          okvt_pkg::KEY_IN_W]);
                    idx_next        = '0;
                    res_val_next    = '0;
                    res_status_next = okvt_pkg::ST_OK;
                    if (s_axis_tuser == okvt_pkg::OP_NOP)
                    begin
                        state_next = S_DONE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    unique case (op_reg)
                        okvt_pkg::OP_LOOKUP:
                        begin
                            res_val_next = okvt_pkg::VAL_OUT_W'(ram_rdata[MW-1:KEY_W]);
                            state_next   = S_DONE;
                        end
                        okvt_pkg::OP_PUT:
                        begin
                            ram_we     = 1'b1;
                            state_next = S_DONE;
                        end
                        okvt_pkg::OP_REMOVE:
                        begin
                            if (more)
                            begin
                                ram_raddr  = idx_inc[AW-1:0];
                                idx_next   = idx_inc[AW-1:0];
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                fill_next  = fill_reg - CW'(1);
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (more)
                begin
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc[AW-1:0];
                end
                else
                begin
                    state_next = S_MISS;
                end
            end

            S_SHIFT:
            begin
                // copy entry idx down to idx-1
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (more)
                begin
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc[AW-1:0];
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_MISS:
            begin
                state_next = S_DONE;
                if (op_reg == okvt_pkg::OP_PUT)
                begin
                    if (fill_reg < CW'(DEPTH))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[AW-1:0];
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        res_status_next = okvt_pkg::ST_FULL;
                    end
                end
                else
                begin
                    res_status_next = okvt_pkg::ST_NOTFOUND;
                end
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_val_next    = res_val_reg;
            out_status_next = res_status_reg;
            out_count_next  = okvt_pkg::CNT_OUT_W'(fill_reg);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_val_reg    <= out_val_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = okvt_pkg::OUT_DATA_W'({out_count_reg, out_val_reg});
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (res_status_reg == okvt_pkg::ST_FULL) |-> fill_reg == CW'(DEPTH))
        else $error("table full reported with free entries");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SEARCH) || (state_reg == S_SHIFT)
                   || (state_reg == S_MISS))
        else $error("store written outside a write step");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> idx_reg != '0 && fill_reg != '0)
        else $error("shift step with nothing to move");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted without processing");
`endif

endmodule
